/* rtl/core/avs_pkg.sv */
// ============================================================================
// avs_pkg
// Types and constants shared by the obstacle avoidance steering blocks.
// ============================================================================
package avs_pkg;

    // Command selector carried on the input tuser
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_ENABLE  = 2'd1,
        CMD_DISABLE = 2'd2,
        CMD_UNKNOWN = 2'd3
    } cmd_kind_t;

    typedef enum logic [2:0] {
        DRV_FWD   = 3'd0,
        DRV_LEFT  = 3'd1,
        DRV_RIGHT = 3'd2,
        DRV_STOP  = 3'd3,
        DRV_NONE  = 3'd4
    } drive_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_FWD   = 3'd1,
        MODE_LEFT  = 3'd2,
        MODE_RIGHT = 3'd3,
        MODE_STOP  = 3'd4
    } action_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_SPEED_FORWARD    = 3'd0;
    localparam logic [2:0] CFG_SPEED_TURN       = 3'd1;
    localparam logic [2:0] CFG_FORWARD_CLEAR_CM = 3'd2;
    localparam logic [2:0] CFG_TURN_START_CM    = 3'd3;
    localparam logic [2:0] CFG_BLOCKED_CM       = 3'd4;
    localparam logic [2:0] CFG_SIDE_DANGER_CM   = 3'd5;
    localparam logic [2:0] CFG_SIDE_MARGIN_CM   = 3'd6;
    localparam logic [2:0] CFG_TURN_HOLD_MS     = 3'd7;

    // Configuration reset values
    localparam logic [9:0]  RST_SPEED_FORWARD    = 10'd700;
    localparam logic [9:0]  RST_SPEED_TURN       = 10'd800;
    localparam logic [9:0]  RST_FORWARD_CLEAR_CM = 10'd30;
    localparam logic [9:0]  RST_TURN_START_CM    = 10'd25;
    localparam logic [9:0]  RST_BLOCKED_CM       = 10'd15;
    localparam logic [9:0]  RST_SIDE_DANGER_CM   = 10'd10;
    localparam logic [7:0]  RST_SIDE_MARGIN_CM   = 8'd4;
    localparam logic [11:0] RST_TURN_HOLD_MS     = 12'd220;

    localparam logic [31:0] DECIDE_PERIOD_MS = 32'd30;
    localparam logic [11:0] SIDE_ADJUST_MS   = 12'd120;
    localparam logic [9:0]  NO_ECHO_CM       = 10'd999;
    localparam logic [9:0]  SLOW_FWD_CAP     = 10'd650;

    // Live configuration handed to the front part; the back part takes the turn speed
    typedef struct packed {
        logic [9:0]  speed_forward;
        logic [9:0]  speed_turn;
        logic [9:0]  forward_clear_cm;
        logic [9:0]  turn_start_cm;
        logic [9:0]  blocked_cm;
        logic [9:0]  side_danger_cm;
        logic [7:0]  side_margin_cm;
        logic [11:0] turn_hold_ms;
    } cfg_t;

    // Classified command: the decision that a fresh tick would take
    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] now_ms;
        drive_t      dec_drive;
        logic [9:0]  dec_speed;
        action_t     dec_action;
        logic        set_hold;
        logic [31:0] hold_deadline;
    } cmd_rec_t;

endpackage

/* rtl/core/avs_front.sv */
// ============================================================================
// avs_front
// Accept command beats, clean distances and pre-compute the tick decision.
// ============================================================================
module avs_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  avs_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_cmd,
    input  logic [31:0]         in_now_ms,
    input  logic [9:0]          in_front_cm,
    input  logic [9:0]          in_left_cm,
    input  logic [9:0]          in_right_cm,
    output logic                rec_valid,
    input  logic                rec_ready,
    output avs_pkg::cmd_rec_t   rec
);

    logic              valid_reg, valid_next;
    avs_pkg::cmd_rec_t rec_reg, rec_next;

    logic [9:0]  front, left, right;
    logic        all_blocked, side_right, side_left, front_clear, front_near;
    logic        pref_right, pref_left;
    logic [10:0] left_plus, right_plus;
    logic [11:0] hold_amount;

    always_comb begin
        front = (in_front_cm == 10'd0) ? avs_pkg::NO_ECHO_CM : in_front_cm;
        left  = (in_left_cm  == 10'd0) ? avs_pkg::NO_ECHO_CM : in_left_cm;
        right = (in_right_cm == 10'd0) ? avs_pkg::NO_ECHO_CM : in_right_cm;

        all_blocked = (front < cfg.blocked_cm) && (left < cfg.blocked_cm)
                   && (right < cfg.blocked_cm);
        front_near  = front < cfg.turn_start_cm;
        front_clear = front >= cfg.forward_clear_cm;
        side_right  = !front_near && (left < cfg.side_danger_cm) && (left < right);
        side_left   = !front_near && (right < cfg.side_danger_cm) && (right < left);

        left_plus  = {1'b0, left}  + {3'b000, cfg.side_margin_cm};
        right_plus = {1'b0, right} + {3'b000, cfg.side_margin_cm};
        pref_right = {1'b0, right} > left_plus;
        pref_left  = {1'b0, left}  > right_plus;

        rec_next            = rec_reg;
        rec_next.kind       = avs_pkg::cmd_kind_t'(in_cmd);
        rec_next.now_ms     = in_now_ms;
        rec_next.set_hold   = 1'b0;
        hold_amount         = cfg.turn_hold_ms;

        // First matching check decides
        if (all_blocked) begin
            rec_next.dec_drive  = avs_pkg::DRV_STOP;
            rec_next.dec_speed  = 10'd0;
            rec_next.dec_action = avs_pkg::MODE_STOP;
        end else if (side_right || side_left) begin
            rec_next.dec_drive  = side_right ? avs_pkg::DRV_RIGHT : avs_pkg::DRV_LEFT;
            rec_next.dec_speed  = cfg.speed_turn;
            rec_next.dec_action = side_right ? avs_pkg::MODE_RIGHT : avs_pkg::MODE_LEFT;
            rec_next.set_hold   = 1'b1;
            hold_amount         = avs_pkg::SIDE_ADJUST_MS;
        end else if (front_clear) begin
            rec_next.dec_drive  = avs_pkg::DRV_FWD;
            rec_next.dec_speed  = cfg.speed_forward;
            rec_next.dec_action = avs_pkg::MODE_FWD;
        end else if (front_near) begin
            if (pref_right || pref_left) begin
                rec_next.dec_drive  = pref_right ? avs_pkg::DRV_RIGHT : avs_pkg::DRV_LEFT;
                rec_next.dec_speed  = cfg.speed_turn;
                rec_next.dec_action = pref_right ? avs_pkg::MODE_RIGHT : avs_pkg::MODE_LEFT;
                rec_next.set_hold   = 1'b1;
            end else begin
                rec_next.dec_drive  = avs_pkg::DRV_STOP;
                rec_next.dec_speed  = 10'd0;
                rec_next.dec_action = avs_pkg::MODE_STOP;
            end
        end else begin
            rec_next.dec_drive  = avs_pkg::DRV_FWD;
            rec_next.dec_speed  = (cfg.speed_forward > avs_pkg::SLOW_FWD_CAP)
                                ? avs_pkg::SLOW_FWD_CAP : cfg.speed_forward;
            rec_next.dec_action = avs_pkg::MODE_FWD;
        end

        rec_next.hold_deadline = in_now_ms + {20'd0, hold_amount};
    end

    assign in_ready  = !valid_reg || rec_ready;
    assign rec_valid = valid_reg;
    assign rec       = rec_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (rec_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            rec_reg <= rec_next;
        end
    end

endmodule

/* rtl/core/avs_queue.sv */
// ============================================================================
// avs_queue
// Short first-in first-out queue of classified commands.
// ============================================================================
module avs_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  avs_pkg::cmd_rec_t   push_rec,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output avs_pkg::cmd_rec_t   head_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    avs_pkg::cmd_rec_t entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = count_reg == FULL_CNT;
    assign not_empty = count_reg != '0;
    assign head_rec  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("queue fill count beyond depth");
`endif

endmodule

/* rtl/core/avs_back.sv */
// ============================================================================
// avs_back
// Apply commands against steering state and register the result beat.
// ============================================================================
module avs_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [9:0]          speed_turn,
    input  logic                rec_valid,
    output logic                rec_pop,
    input  avs_pkg::cmd_rec_t   rec,
    output logic                out_valid,
    input  logic                out_ready,
    output avs_pkg::drive_t     out_drive,
    output logic [9:0]          out_speed,
    output avs_pkg::action_t    out_action
);

    logic             enabled_reg, enabled_next;
    logic [31:0]      last_reg, last_next;
    logic [31:0]      hold_reg, hold_next;
    avs_pkg::action_t action_reg, action_next;

    logic             valid_reg, valid_next;
    avs_pkg::drive_t  drive_reg, drive_next;
    logic [9:0]       speed_reg, speed_next;
    avs_pkg::action_t res_action_reg, res_action_next;

    logic             emit;
    logic [31:0]      since_last;

    assign rec_pop = rec_valid && (!valid_reg || out_ready);
    assign since_last = rec.now_ms - last_reg;

    always_comb begin
        enabled_next    = enabled_reg;
        last_next       = last_reg;
        hold_next       = hold_reg;
        action_next     = action_reg;
        emit            = 1'b0;
        drive_next      = drive_reg;
        speed_next      = speed_reg;
        res_action_next = res_action_reg;

        if (rec_pop) begin
            case (rec.kind)
                avs_pkg::CMD_ENABLE: begin
                    enabled_next = 1'b1;
                    last_next    = '0;
                    hold_next    = '0;
                    action_next  = avs_pkg::MODE_IDLE;
                    emit         = 1'b1;
                    drive_next   = avs_pkg::DRV_NONE;
                    speed_next   = 10'd0;
                end
                avs_pkg::CMD_DISABLE: begin
                    enabled_next = 1'b0;
                    hold_next    = '0;
                    action_next  = avs_pkg::MODE_STOP;
                    emit         = 1'b1;
                    drive_next   = avs_pkg::DRV_STOP;
                    speed_next   = 10'd0;
                end
                avs_pkg::CMD_TICK: begin
                    if (enabled_reg && (since_last >= avs_pkg::DECIDE_PERIOD_MS)) begin
                        last_next = rec.now_ms;
                        emit      = 1'b1;
                        if (rec.now_ms < hold_reg) begin
                            // Repeat the held turn, keep the action
                            if (action_reg == avs_pkg::MODE_LEFT) begin
                                drive_next = avs_pkg::DRV_LEFT;
                                speed_next = speed_turn;
                            end else if (action_reg == avs_pkg::MODE_RIGHT) begin
                                drive_next = avs_pkg::DRV_RIGHT;
                                speed_next = speed_turn;
                            end else begin
                                drive_next = avs_pkg::DRV_NONE;
                                speed_next = 10'd0;
                            end
                        end else begin
                            action_next = rec.dec_action;
                            drive_next  = rec.dec_drive;
                            speed_next  = rec.dec_speed;
                            if (rec.set_hold) begin
                                hold_next = rec.hold_deadline;
                            end
                        end
                    end
                end
                default: begin
                    // Unknown command: drop
                end
            endcase
            res_action_next = action_next;
        end

        if (emit) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
            last_reg    <= '0;
            hold_reg    <= '0;
            action_reg  <= avs_pkg::MODE_IDLE;
            valid_reg   <= 1'b0;
        end else begin
            enabled_reg <= enabled_next;
            last_reg    <= last_next;
            hold_reg    <= hold_next;
            action_reg  <= action_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            drive_reg      <= drive_next;
            speed_reg      <= speed_next;
            res_action_reg <= res_action_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_drive  = drive_reg;
    assign out_speed  = speed_reg;
    assign out_action = res_action_reg;

`ifndef SYNTHESIS
    a_enable_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (rec_pop && rec.kind == avs_pkg::CMD_ENABLE)
        |=> (valid_reg && res_action_reg == avs_pkg::MODE_IDLE && enabled_reg))
        else $error("enable beat did not give an idle result");

    a_disable_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (rec_pop && rec.kind == avs_pkg::CMD_DISABLE)
        |=> (!enabled_reg && hold_reg == '0 && action_reg == avs_pkg::MODE_STOP))
        else $error("disable beat left steering state live");

    a_idle_tick_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (rec_pop && rec.kind == avs_pkg::CMD_TICK && !enabled_reg)
        |=> (!valid_reg && $stable(action_reg)))
        else $error("tick while disabled produced a result");
`endif

endmodule

/* rtl/core/obstacle_avoid_steering_unit.sv */
// ============================================================================
// obstacle_avoid_steering_unit
// Steering decisions for an obstacle-avoiding car from ultrasonic distances.
// ============================================================================
// Path: an accepted command beat passes the front stage, the queue and the result
//   register in that order; a stall on either side can hold it along the way.
// Throughput: one command beat per cycle unless the queue is full; the back part
//   retires one queued command per cycle unless its result beat waits untaken.
// Reset: aresetn (synchronous, active low) disables steering, clears times
//   and action to idle, empties the queue and restores register defaults.
module obstacle_avoid_steering_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Command input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // now_ms[31:0], front_cm[41:32],
                                   // left_cm[51:42], right_cm[61:52], zero[63:62]
    input  logic [1:0]  s_tuser,   // cmd[1:0]

    // Result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // drive[2:0], drive_speed[12:3], action[15:13]

    // Configuration writes
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_index,
    input  logic [11:0] cfg_wr_data
);

    avs_pkg::cfg_t     cfg_reg, cfg_next;

    logic              front_valid, front_ready;
    avs_pkg::cmd_rec_t front_rec;
    logic              q_full, q_not_empty, q_pop;
    avs_pkg::cmd_rec_t q_head;

    avs_pkg::drive_t   res_drive;
    logic [9:0]        res_speed;
    avs_pkg::action_t  res_action;

    // ---------------------------------------------------------------------
    // Configuration registers: take a write whenever the enable is high
    // ---------------------------------------------------------------------
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                avs_pkg::CFG_SPEED_FORWARD:    cfg_next.speed_forward    = cfg_wr_data[9:0];
                avs_pkg::CFG_SPEED_TURN:       cfg_next.speed_turn       = cfg_wr_data[9:0];
                avs_pkg::CFG_FORWARD_CLEAR_CM: cfg_next.forward_clear_cm = cfg_wr_data[9:0];
                avs_pkg::CFG_TURN_START_CM:    cfg_next.turn_start_cm    = cfg_wr_data[9:0];
                avs_pkg::CFG_BLOCKED_CM:       cfg_next.blocked_cm       = cfg_wr_data[9:0];
                avs_pkg::CFG_SIDE_DANGER_CM:   cfg_next.side_danger_cm   = cfg_wr_data[9:0];
                avs_pkg::CFG_SIDE_MARGIN_CM:   cfg_next.side_margin_cm   = cfg_wr_data[7:0];
                avs_pkg::CFG_TURN_HOLD_MS:     cfg_next.turn_hold_ms     = cfg_wr_data;
                default: begin
                    // Nothing else to write
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_forward    <= avs_pkg::RST_SPEED_FORWARD;
            cfg_reg.speed_turn       <= avs_pkg::RST_SPEED_TURN;
            cfg_reg.forward_clear_cm <= avs_pkg::RST_FORWARD_CLEAR_CM;
            cfg_reg.turn_start_cm    <= avs_pkg::RST_TURN_START_CM;
            cfg_reg.blocked_cm       <= avs_pkg::RST_BLOCKED_CM;
            cfg_reg.side_danger_cm   <= avs_pkg::RST_SIDE_DANGER_CM;
            cfg_reg.side_margin_cm   <= avs_pkg::RST_SIDE_MARGIN_CM;
            cfg_reg.turn_hold_ms     <= avs_pkg::RST_TURN_HOLD_MS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------------------------------------------------------------
    // Front: accept the beat, substitute missing echoes, pre-decide the tick
    // ---------------------------------------------------------------------
    avs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser),
        .in_now_ms   (s_tdata[31:0]),
        .in_front_cm (s_tdata[41:32]),
        .in_left_cm  (s_tdata[51:42]),
        .in_right_cm (s_tdata[61:52]),
        .rec_valid   (front_valid),
        .rec_ready   (front_ready),
        .rec         (front_rec)
    );

    // Hold the front stage while the queue is full
    assign front_ready = !q_full;

    // ---------------------------------------------------------------------
    // Queue between front and back so either side can stall on its own
    // ---------------------------------------------------------------------
    avs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_valid),
        .push_rec  (front_rec),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_rec  (q_head)
    );

    // ---------------------------------------------------------------------
    // Back: gate the tick on period and hold, update state, emit the beat
    // ---------------------------------------------------------------------
    avs_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .speed_turn (cfg_reg.speed_turn),
        .rec_valid  (q_not_empty),
        .rec_pop    (q_pop),
        .rec        (q_head),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_drive  (res_drive),
        .out_speed  (res_speed),
        .out_action (res_action)
    );

    assign m_tdata = {res_action, res_speed, res_drive};

endmodule

/* verif/tb_obstacle_avoid_steering_unit.sv */
// ============================================================================
// tb_obstacle_avoid_steering_unit
// Self-checking bench for the steering decision unit. A scoreboard class holds
// its own copy of the steering state and registers, predicts the result beat
// each accepted command beat yields, if any, and checks the result stream in order.
// Directed commands go first, then random drive sessions under several register
// settings, with random stalls on both sides and one long result hold-off.
// ============================================================================
module tb_obstacle_avoid_steering_unit;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int QUIET_LIMIT    = 4000;  // cycles with no beat, no write
    localparam int DRAIN_CYCLES   = 12;    // front stage, queue, result reg
    localparam int HOLDOFF_CYCLES = 64;
    localparam int PHASE_ITEMS    = 210;
    localparam int IDLE_PCT       = 32;

    // Decision constants of the steering scheme
    localparam logic [31:0] DECISION_GAP_MS = 32'd30;
    localparam logic [31:0] WALL_HOLD_MS    = 32'd120;
    localparam logic [9:0]  NO_ECHO         = 10'd999;
    localparam logic [9:0]  SLOW_CAP        = 10'd650;

    typedef struct packed {
        avs_pkg::drive_t  drive;
        logic [9:0]       speed;
        avs_pkg::action_t action;
    } steer_out_t;

    // ------------------------------------------------------------------------
    // Scoreboard: steering state, registers and the queue of awaited results
    // ------------------------------------------------------------------------
    class steer_scoreboard;
        logic [9:0]       fwd_speed, turn_speed, clear_cm, avoid_cm, stuck_cm, wall_cm;
        logic [7:0]       margin_cm;
        logic [11:0]      hold_ms;
        bit               steer_on;
        logic [31:0]      last_decision_ms, hold_end_ms;
        avs_pkg::action_t cur_act;
        steer_out_t       pending[$];
        int errors, n_cmds, n_results, n_ignored, n_hold, n_hold_none;

        function void restore_defaults();
            fwd_speed        = 10'd700;
            turn_speed       = 10'd800;
            clear_cm         = 10'd30;
            avoid_cm         = 10'd25;
            stuck_cm         = 10'd15;
            wall_cm          = 10'd10;
            margin_cm        = 8'd4;
            hold_ms          = 12'd220;
            steer_on         = 1'b0;
            last_decision_ms = '0;
            hold_end_ms      = '0;
            cur_act          = avs_pkg::MODE_IDLE;
        endfunction

        function void write_reg(logic [2:0] idx, logic [11:0] val);
            case (idx)
                avs_pkg::CFG_SPEED_FORWARD:    fwd_speed  = val[9:0];
                avs_pkg::CFG_SPEED_TURN:       turn_speed = val[9:0];
                avs_pkg::CFG_FORWARD_CLEAR_CM: clear_cm   = val[9:0];
                avs_pkg::CFG_TURN_START_CM:    avoid_cm   = val[9:0];
                avs_pkg::CFG_BLOCKED_CM:       stuck_cm   = val[9:0];
                avs_pkg::CFG_SIDE_DANGER_CM:   wall_cm    = val[9:0];
                avs_pkg::CFG_SIDE_MARGIN_CM:   margin_cm  = val[7:0];
                avs_pkg::CFG_TURN_HOLD_MS:     hold_ms    = val;
                default: ;
            endcase
        endfunction

        function void expect_out(avs_pkg::drive_t drv, logic [9:0] spd);
            steer_out_t o;
            o.drive  = drv;
            o.speed  = spd;
            o.action = cur_act;
            pending.push_back(o);
        endfunction

        function int unsigned echo_dist(logic [9:0] raw);
            return (raw == 10'd0) ? NO_ECHO : raw;
        endfunction

        function void decide_tick(logic [31:0] now, int unsigned f, int unsigned l,
                                  int unsigned r);
            if (!steer_on || (now - last_decision_ms) < DECISION_GAP_MS) begin
                n_ignored++;
                return;
            end
            last_decision_ms = now;
            // a running hold repeats the held turn, or issues a result with no drive
            if (now < hold_end_ms) begin
                n_hold++;
                case (cur_act)
                    avs_pkg::MODE_LEFT:  expect_out(avs_pkg::DRV_LEFT, turn_speed);
                    avs_pkg::MODE_RIGHT: expect_out(avs_pkg::DRV_RIGHT, turn_speed);
                    default: begin
                        n_hold_none++;
                        expect_out(avs_pkg::DRV_NONE, 10'd0);
                    end
                endcase
                return;
            end
            if (f < stuck_cm && l < stuck_cm && r < stuck_cm) begin
                cur_act = avs_pkg::MODE_STOP;
                expect_out(avs_pkg::DRV_STOP, 10'd0);
                return;
            end
            if (f >= avoid_cm) begin
                if (l < wall_cm && l < r) begin
                    cur_act     = avs_pkg::MODE_RIGHT;
                    hold_end_ms = now + WALL_HOLD_MS;
                    expect_out(avs_pkg::DRV_RIGHT, turn_speed);
                    return;
                end
                if (r < wall_cm && r < l) begin
                    cur_act     = avs_pkg::MODE_LEFT;
                    hold_end_ms = now + WALL_HOLD_MS;
                    expect_out(avs_pkg::DRV_LEFT, turn_speed);
                    return;
                end
            end
            if (f >= clear_cm) begin
                cur_act = avs_pkg::MODE_FWD;
                expect_out(avs_pkg::DRV_FWD, fwd_speed);
                return;
            end
            if (f < avoid_cm) begin
                if (r > l + margin_cm) begin
                    cur_act     = avs_pkg::MODE_RIGHT;
                    hold_end_ms = now + hold_ms;
                    expect_out(avs_pkg::DRV_RIGHT, turn_speed);
                end else if (l > r + margin_cm) begin
                    cur_act     = avs_pkg::MODE_LEFT;
                    hold_end_ms = now + hold_ms;
                    expect_out(avs_pkg::DRV_LEFT, turn_speed);
                end else begin
                    cur_act = avs_pkg::MODE_STOP;
                    expect_out(avs_pkg::DRV_STOP, 10'd0);
                end
                return;
            end
            // buffer band between turn start and forward clear: slow forward
            cur_act = avs_pkg::MODE_FWD;
            expect_out(avs_pkg::DRV_FWD, (fwd_speed > SLOW_CAP) ? SLOW_CAP : fwd_speed);
        endfunction

        function void note_command(logic [1:0] user, logic [63:0] data);
            n_cmds++;
            case (avs_pkg::cmd_kind_t'(user))
                avs_pkg::CMD_ENABLE: begin
                    steer_on         = 1'b1;
                    last_decision_ms = '0;
                    hold_end_ms      = '0;
                    cur_act          = avs_pkg::MODE_IDLE;
                    expect_out(avs_pkg::DRV_NONE, 10'd0);
                end
                avs_pkg::CMD_DISABLE: begin
                    steer_on    = 1'b0;
                    hold_end_ms = '0;
                    cur_act     = avs_pkg::MODE_STOP;
                    expect_out(avs_pkg::DRV_STOP, 10'd0);
                end
                avs_pkg::CMD_TICK: decide_tick(data[31:0], echo_dist(data[41:32]),
                                               echo_dist(data[51:42]),
                                               echo_dist(data[61:52]));
                default: n_ignored++;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [15:0] beat);
            steer_out_t want;
            logic [2:0] drv, act;
            logic [9:0] spd;
            drv = beat[2:0];
            spd = beat[12:3];
            act = beat[15:13];
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result drive=%0d speed=%0d action=%0d",
                                          drv, spd, act));
                return;
            end
            want = pending.pop_front();
            n_results++;
            if (drv !== want.drive)
                report_mismatch($sformatf("drive %0d, want %0d", drv, want.drive));
            if (spd !== want.speed)
                report_mismatch($sformatf("drive_speed %0d, want %0d", spd, want.speed));
            if (act !== want.action)
                report_mismatch($sformatf("action %0d, want %0d", act, want.action));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block
    // ------------------------------------------------------------------------
    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_tvalid     = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata      = '0;   // now_ms[31:0], front_cm[41:32],
                                      // left_cm[51:42], right_cm[61:52], zero[63:62]
    logic [1:0]  s_tuser      = '0;   // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready     = 1'b0;
    logic [15:0] m_tdata;             // drive[2:0], drive_speed[12:3], action[15:13]
    logic        cfg_wr_en    = 1'b0;
    logic [2:0]  cfg_wr_index = '0;
    logic [11:0] cfg_wr_data  = '0;

    steer_scoreboard sb;
    bit          calm          = 1'b0;  // no random idling on either side while set
    int          holdoff_req   = 0;
    int          holdoff_seen  = 0;
    int          holdoff_cnt   = 0;
    int          quiet         = 0;
    int          n_settings    = 0;
    logic [31:0] clock_ms      = '0;

    obstacle_avoid_steering_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // Check every result beat as it is taken
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Result side: random stalls, a calm stretch, and one long hold-off
    // counted here so that the sender keeps offering beats meanwhile
    always @(posedge aclk) begin
        if (holdoff_cnt != 0) begin
            m_tready    <= 1'b0;
            holdoff_cnt <= holdoff_cnt - 1;
        end else if (holdoff_req != holdoff_seen) begin
            holdoff_seen <= holdoff_req;
            holdoff_cnt  <= HOLDOFF_CYCLES;
            m_tready     <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles", QUIET_LIMIT);
            $display("FAIL obstacle_avoid_steering_unit");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------

    // Offer one command beat, idling first at random; note it once taken
    task automatic send_command(avs_pkg::cmd_kind_t kind, logic [31:0] now,
                                logic [9:0] f, logic [9:0] l, logic [9:0] r);
        logic [63:0] data;
        data = {2'b00, r, l, f, now};
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        sb.note_command(kind, data);
    endtask

    // Hold the input until every awaited result is out, then let any ignored
    // command still in flight clear the pipe
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [11:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic apply_setting(int fwd, int turn, int clear, int avoid, int stuck,
                                 int wall, int margin, int hold);
        drain();
        write_reg(avs_pkg::CFG_SPEED_FORWARD,    12'(fwd));
        write_reg(avs_pkg::CFG_SPEED_TURN,       12'(turn));
        write_reg(avs_pkg::CFG_FORWARD_CLEAR_CM, 12'(clear));
        write_reg(avs_pkg::CFG_TURN_START_CM,    12'(avoid));
        write_reg(avs_pkg::CFG_BLOCKED_CM,       12'(stuck));
        write_reg(avs_pkg::CFG_SIDE_DANGER_CM,   12'(wall));
        write_reg(avs_pkg::CFG_SIDE_MARGIN_CM,   12'(margin));
        write_reg(avs_pkg::CFG_TURN_HOLD_MS,     12'(hold));
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Plausible thresholds so that every branch of the decision gets hit
    task automatic apply_random_setting();
        int clear, avoid;
        clear = $urandom_range(8, 90);
        avoid = $urandom_range(4, clear + 8);
        apply_setting($urandom_range(0, 1023), $urandom_range(0, 1023), clear, avoid,
                      $urandom_range(3, 40), $urandom_range(3, 40),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 12),
                      $urandom_range(0, 4095));
    endtask

    // Distance biased towards the live thresholds, with no-echo and extremes
    function automatic logic [9:0] pick_dist();
        int sel, base;
        sel = $urandom_range(0, 99);
        if (sel < 10) return 10'd0;
        if (sel < 22) return 10'($urandom_range(0, 1023));
        if (sel < 26) return 10'd1023;
        case ($urandom_range(0, 3))
            0:       base = sb.clear_cm;
            1:       base = sb.avoid_cm;
            2:       base = sb.stuck_cm;
            default: base = sb.wall_cm;
        endcase
        base = base + $urandom_range(0, 6) - 3;
        if (base < 0) base = 0;
        if (base > 1023) base = 1023;
        return 10'(base);
    endfunction

    // Second side: often just around the turn margin from the first side
    function automatic logic [9:0] pick_side(logic [9:0] other);
        int o, v;
        if ($urandom_range(0, 99) >= 35) return pick_dist();
        o = (other == 10'd0) ? NO_ECHO : other;
        v = o + sb.margin_cm + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1) == 1) v = o - sb.margin_cm - $urandom_range(0, 2) + 1;
        if (v < 1) v = 1;
        if (v > 1023) v = 1023;
        return 10'(v);
    endfunction

    // Random drive sessions: mostly decision ticks at a sane pace while
    // enabled, plus enable, disable, unknown commands, early ticks, time jumps
    // and ticks aimed back into a running hold
    task automatic run_phase(int items);
        int                 pick, sel;
        avs_pkg::cmd_kind_t kind;
        logic [31:0]        now;
        logic [9:0]         f, l, r;
        for (int i = 0; i < items; i++) begin
            pick = $urandom_range(0, 99);
            f    = pick_dist();
            l    = pick_dist();
            r    = pick_side(l);
            if (!sb.steer_on && pick >= 8)
                kind = ($urandom_range(0, 3) != 0) ? avs_pkg::CMD_ENABLE
                                                   : avs_pkg::CMD_TICK;
            else if (pick < 3)
                kind = avs_pkg::CMD_ENABLE;
            else if (pick < 6)
                kind = avs_pkg::CMD_DISABLE;
            else if (pick < 8)
                kind = avs_pkg::CMD_UNKNOWN;
            else
                kind = avs_pkg::CMD_TICK;
            if (kind != avs_pkg::CMD_TICK) begin
                now = $urandom;
            end else if (pick >= 8 && pick < 13) begin
                now = sb.hold_end_ms - 1 - $urandom_range(0, 60);
            end else begin
                sel = $urandom_range(0, 99);
                if (sel < 80)
                    clock_ms = clock_ms + 30 + $urandom_range(0, 60);
                else if (sel < 92)
                    clock_ms = clock_ms + $urandom_range(0, 29);
                else
                    clock_ms = $urandom;
                now = clock_ms;
            end
            send_command(kind, now, f, l, r);
        end
    endtask

    // Directed commands at the reset register values
    task automatic run_directed();
        // tick while disabled, unknown command, disable, enable
        send_command(avs_pkg::CMD_TICK,    32'd100, 10'd40, 10'd40, 10'd40);
        send_command(avs_pkg::CMD_UNKNOWN, 32'hFFFF_FFFF, 10'd1023, 10'd1023, 10'd1023);
        send_command(avs_pkg::CMD_DISABLE, 32'd0, 10'd0, 10'd0, 10'd0);
        send_command(avs_pkg::CMD_ENABLE,  32'd0, 10'd0, 10'd0, 10'd0);
        // too soon after enable, then exactly at the decision period
        send_command(avs_pkg::CMD_TICK, 32'd10,  10'd50, 10'd50, 10'd50);
        send_command(avs_pkg::CMD_TICK, 32'd30,  10'd5,  10'd5,  10'd5);   // boxed in
        send_command(avs_pkg::CMD_TICK, 32'd60,  10'd0,  10'd0,  10'd0);   // no echo
        send_command(avs_pkg::CMD_TICK, 32'd90,  10'd40, 10'd5,  10'd50);  // wall left
        send_command(avs_pkg::CMD_TICK, 32'd120, 10'd40, 10'd40, 10'd40);  // held turn
        send_command(avs_pkg::CMD_TICK, 32'd220, 10'd1023, 10'd1023, 10'd8); // wall right
        send_command(avs_pkg::CMD_TICK, 32'd400, 10'd27, 10'd20, 10'd20);  // buffer band
        send_command(avs_pkg::CMD_TICK, 32'd430, 10'd20, 10'd10, 10'd15);  // avoid right
        send_command(avs_pkg::CMD_TICK, 32'd700, 10'd10, 10'd30, 10'd20);  // avoid left
        send_command(avs_pkg::CMD_TICK, 32'd1000, 10'd10, 10'd20, 10'd22); // no free side
        send_command(avs_pkg::CMD_TICK, 32'd1030, 10'd24, 10'd3,  10'd3);
        // hold running while the action is forward: time jumps back into it
        send_command(avs_pkg::CMD_TICK, 32'd1100, 10'd20, 10'd5,  10'd50);
        send_command(avs_pkg::CMD_TICK, 32'd5000, 10'd0,  10'd0,  10'd0);
        send_command(avs_pkg::CMD_TICK, 32'd1200, 10'd20, 10'd20, 10'd20);
        // hold deadline wrapping past the top of the time range
        send_command(avs_pkg::CMD_TICK, 32'hFFFF_FFF0, 10'd20, 10'd50, 10'd5);
        send_command(avs_pkg::CMD_TICK, 32'h0000_000E, 10'd20, 10'd20, 10'd20);
        send_command(avs_pkg::CMD_TICK, 32'h0000_0100, 10'd1023, 10'd1023, 10'd1023);
        send_command(avs_pkg::CMD_DISABLE, 32'd0, 10'd0, 10'd0, 10'd0);
        send_command(avs_pkg::CMD_TICK, 32'h0000_1000, 10'd50, 10'd50, 10'd50);
        send_command(avs_pkg::CMD_ENABLE, 32'd0, 10'd0, 10'd0, 10'd0);
    endtask

    // ------------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        sb.restore_defaults();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        // extremes of every register
        apply_setting(0, 0, 0, 0, 0, 0, 0, 0);
        clock_ms = $urandom;
        run_phase(PHASE_ITEMS);
        apply_setting(1023, 1023, 1023, 1023, 1023, 1023, 255, 4095);
        run_phase(PHASE_ITEMS);

        // near the time wrap; calm stretch with the long result hold-off in it
        apply_random_setting();
        clock_ms = 32'hFFFF_FF00;
        run_phase(40);
        calm = 1'b1;
        run_phase(20);
        holdoff_req++;
        run_phase(PHASE_ITEMS - 60);
        calm = 1'b0;

        apply_random_setting();
        run_phase(PHASE_ITEMS);
        apply_random_setting();
        run_phase(PHASE_ITEMS);

        // back to the reset values
        apply_setting(700, 800, 30, 25, 15, 10, 4, 220);
        run_phase(PHASE_ITEMS);

        drain();
        $display("Run: %0d commands under %0d register settings, %0d results checked",
                 sb.n_cmds, n_settings, sb.n_results);
        $display("Run: %0d ignored, %0d ticks inside a turn hold (%0d with no turn), %0d errors",
                 sb.n_ignored, sb.n_hold, sb.n_hold_none, sb.errors);
        if (sb.errors == 0) begin
            $display("PASS obstacle_avoid_steering_unit");
        end else begin
            $display("FAIL obstacle_avoid_steering_unit");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/avs_pkg.sv
rtl/core/avs_front.sv
rtl/core/avs_queue.sv
rtl/core/avs_back.sv
rtl/core/obstacle_avoid_steering_unit.sv
verif/tb_obstacle_avoid_steering_unit.sv
